[src/vpp_pkg.sv]
// vpp_pkg: shared types, constants and the divider step for the projection unit
// no dependencies
package vpp_pkg;

   localparam int WordCount = 12;
   localparam int TransBase = 9;
   localparam int DivSteps  = 32;
   localparam int DvsW      = 23;

   localparam logic signed [31:0] ScreenW  = 32'sd320;
   localparam logic signed [31:0] ScreenH  = 32'sd200;
   localparam logic signed [31:0] GuardXLo = -32'sd40;
   localparam logic signed [31:0] GuardXHi = 32'sd360;
   localparam logic signed [31:0] GuardYLo = -32'sd100;
   localparam logic signed [31:0] GuardYHi = 32'sd300;
   localparam logic signed [9:0]  ClampXLo = -10'sd39;
   localparam logic signed [9:0]  ClampXHi = 10'sd359;
   localparam logic signed [9:0]  ClampYLo = -10'sd99;
   localparam logic signed [9:0]  ClampYHi = 10'sd299;

   localparam logic [15:0] CenterXReset = 16'd160;
   localparam logic [15:0] CenterYReset = 16'd100;

   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_VERTEX = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1
   } csr_index_type;

   // side data that rides along with the quotient lanes
   typedef struct packed {
      logic            behind;
      logic [23:0]     depth;
      logic            neg_x;
      logic            neg_y;
      logic [DvsW-1:0] dvs;
   } div_ctl_type;

   // partial remainder and dividend bits shifting out / quotient bits shifting in
   typedef struct packed {
      logic [DvsW-1:0] rem;
      logic [31:0]     nq;
   } div_lane_type;

   function automatic div_lane_type div_step(div_lane_type a, logic [DvsW-1:0] d);
      logic [DvsW:0]   t;
      logic [DvsW+1:0] diff;
      div_lane_type    r;
      t    = {a.rem, a.nq[31]};
      diff = {1'b0, t} - {2'b00, d};
      if (diff[DvsW+1]) begin
         r.rem = t[DvsW-1:0];
         r.nq  = {a.nq[30:0], 1'b0};
      end else begin
         r.rem = diff[DvsW-1:0];
         r.nq  = {a.nq[30:0], 1'b1};
      end
      return r;
   endfunction

endpackage

[src/vertex_perspective_project_clip_unit.sv]
// pipeline: 36 register stages: products, row sums, divider setup, 32 bit stages
// of the divider and the result register
// throughput: one transaction per cycle; the whole pipeline holds while a result is stalled
// load transactions write the transform word at once and produce no result
// reset: pipeline valids cleared, transform words zero, center 160,100
module vertex_perspective_project_clip_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [3:0]  req_coeff_index,
   input  logic [31:0] req_coeff_value,
   input  logic [31:0] req_vertex_x,
   input  logic [31:0] req_vertex_y,
   input  logic [31:0] req_vertex_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_depth,
   output logic [9:0]  rsp_pix_x,
   output logic [9:0]  rsp_pix_y,
   output logic [3:0]  rsp_edge_flags,
   output logic        rsp_behind_eye,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import vpp_pkg::*;

   logic        adv, accept;
   logic [15:0] cx_ff, cy_ff;
   logic        xf_valid, dv_valid;
   div_ctl_type xf_ctl, dv_ctl;
   logic [31:0] nx, ny, qx, qy;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= CenterXReset;
         cy_ff <= CenterYReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X: cx_ff <= csr_wdata;
            CSR_CENTER_Y: cy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   vpp_xform u_xform (
      .clock, .reset, .adv, .accept,
      .func(req_func), .coeff_index(req_coeff_index), .coeff_value(req_coeff_value),
      .vertex_x(req_vertex_x), .vertex_y(req_vertex_y), .vertex_z(req_vertex_z),
      .out_valid(xf_valid), .out_ctl(xf_ctl), .out_num_x(nx), .out_num_y(ny)
   );

   vpp_div u_div (
      .clock, .reset, .adv,
      .in_valid(xf_valid), .in_ctl(xf_ctl), .in_num_x(nx), .in_num_y(ny),
      .out_valid(dv_valid), .out_ctl(dv_ctl), .out_q_x(qx), .out_q_y(qy)
   );

   vpp_screen u_screen (
      .clock, .reset, .adv,
      .in_valid(dv_valid), .in_ctl(dv_ctl), .in_q_x(qx), .in_q_y(qy),
      .center_x(cx_ff), .center_y(cy_ff),
      .out_valid(rsp_valid), .out_depth(rsp_depth), .out_pix_x(rsp_pix_x),
      .out_pix_y(rsp_pix_y), .out_edge_flags(rsp_edge_flags),
      .out_behind_eye(rsp_behind_eye)
   );

endmodule

[src/vpp_xform.sv]
// vpp_xform: transform word store, row products, row sums and divider setup
// depends on vpp_pkg
module vpp_xform (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 accept,
   input  logic                 func,
   input  logic [3:0]           coeff_index,
   input  logic [31:0]          coeff_value,
   input  logic [31:0]          vertex_x,
   input  logic [31:0]          vertex_y,
   input  logic [31:0]          vertex_z,
   output logic                 out_valid,
   output vpp_pkg::div_ctl_type out_ctl,
   output logic [31:0]          out_num_x,
   output logic [31:0]          out_num_y
);
   import vpp_pkg::*;

   logic [31:0] words_ff [WordCount];
   logic [31:0] prod_ff [3][3];
   logic [31:0] prod_in [3][3];
   logic [31:0] trans_ff [3];
   logic [31:0] sum_ff [3];
   logic [31:0] sum_in [3];
   logic        v1_ff, v2_ff, v3_ff;
   logic [31:0] vec [3];
   div_ctl_type ctl_ff, ctl_in;
   logic [31:0] nx_ff, ny_ff, nx_in, ny_in;

   assign vec[0] = vertex_x;
   assign vec[1] = vertex_y;
   assign vec[2] = vertex_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WordCount; i++) words_ff[i] <= '0;
      end else if (accept && func == FUNC_LOAD && coeff_index < 4'(WordCount)) begin
         words_ff[coeff_index] <= coeff_value;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            prod_in[r][c] = words_ff[r*3+c] * vec[c];
      for (int r = 0; r < 3; r++)
         sum_in[r] = prod_ff[r][0] + prod_ff[r][1] + prod_ff[r][2] + trans_ff[r];
   end

   always_comb begin
      ctl_in.depth  = sum_ff[2][31:8];
      ctl_in.behind = sum_ff[2][31] || (sum_ff[2][31:8] == 24'd0);
      ctl_in.dvs    = sum_ff[2][30:8];
      ctl_in.neg_x  = sum_ff[0][31];
      ctl_in.neg_y  = sum_ff[1][31];
      nx_in = sum_ff[0][31] ? (32'd0 - sum_ff[0]) : sum_ff[0];
      ny_in = sum_ff[1][31] ? (32'd0 - sum_ff[1]) : sum_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept && func == FUNC_VERTEX;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         for (int r = 0; r < 3; r++) trans_ff[r] <= words_ff[TransBase+r];
         sum_ff <= sum_in;
         ctl_ff <= ctl_in;
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_ctl   = ctl_ff;
   assign out_num_x = nx_ff;
   assign out_num_y = ny_ff;

endmodule

[src/vpp_div.sv]
// vpp_div: two restoring dividers, one quotient bit per pipeline stage
// depends on vpp_pkg
module vpp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  vpp_pkg::div_ctl_type in_ctl,
   input  logic [31:0]          in_num_x,
   input  logic [31:0]          in_num_y,
   output logic                 out_valid,
   output vpp_pkg::div_ctl_type out_ctl,
   output logic [31:0]          out_q_x,
   output logic [31:0]          out_q_y
);
   import vpp_pkg::*;

   logic         v_ff   [DivSteps];
   div_ctl_type  ctl_ff [DivSteps];
   div_lane_type lx_ff  [DivSteps];
   div_lane_type ly_ff  [DivSteps];

   genvar g;
   generate
      for (g = 0; g < DivSteps; g++) begin : g_step
         logic         v_src;
         div_ctl_type  c_src;
         div_lane_type x_src, y_src;
         if (g == 0) begin : g_first
            assign v_src = in_valid;
            assign c_src = in_ctl;
            assign x_src = '{rem: '0, nq: in_num_x};
            assign y_src = '{rem: '0, nq: in_num_y};
         end else begin : g_rest
            assign v_src = v_ff[g-1];
            assign c_src = ctl_ff[g-1];
            assign x_src = lx_ff[g-1];
            assign y_src = ly_ff[g-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[g] <= 1'b0;
            end else if (adv) begin
               v_ff[g] <= v_src;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               ctl_ff[g] <= c_src;
               lx_ff[g]  <= div_step(x_src, c_src.dvs);
               ly_ff[g]  <= div_step(y_src, c_src.dvs);
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[DivSteps-1];
   assign out_ctl   = ctl_ff[DivSteps-1];
   assign out_q_x   = lx_ff[DivSteps-1].nq;
   assign out_q_y   = ly_ff[DivSteps-1].nq;

endmodule

[src/vpp_screen.sv]
// vpp_screen: quotient sign, screen center, clip bits, clamp and result register
// depends on vpp_pkg
module vpp_screen (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  vpp_pkg::div_ctl_type in_ctl,
   input  logic [31:0]          in_q_x,
   input  logic [31:0]          in_q_y,
   input  logic [15:0]          center_x,
   input  logic [15:0]          center_y,
   output logic                 out_valid,
   output logic [23:0]          out_depth,
   output logic [9:0]           out_pix_x,
   output logic [9:0]           out_pix_y,
   output logic [3:0]           out_edge_flags,
   output logic                 out_behind_eye
);
   import vpp_pkg::*;

   logic signed [31:0] px, py;
   logic [9:0]  sx_in, sy_in, sx_ff, sy_ff;
   logic [3:0]  fl_in, fl_ff;
   logic [23:0] dep_ff;
   logic        be_ff, v_ff;

   always_comb begin
      px = (in_ctl.neg_x ? (32'd0 - in_q_x) : in_q_x) + {{16{center_x[15]}}, center_x};
      py = {{16{center_y[15]}}, center_y} - (in_ctl.neg_y ? (32'd0 - in_q_y) : in_q_y);
      fl_in = {py >= ScreenH, py < 0, px >= ScreenW, px < 0};
      if (px <= GuardXLo)      sx_in = ClampXLo;
      else if (px >= GuardXHi) sx_in = ClampXHi;
      else                     sx_in = px[9:0];
      if (py <= GuardYLo)      sy_in = ClampYLo;
      else if (py >= GuardYHi) sy_in = ClampYHi;
      else                     sy_in = py[9:0];
      if (in_ctl.behind) begin
         sx_in = '0;
         sy_in = '0;
         fl_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         fl_ff  <= fl_in;
         dep_ff <= in_ctl.depth;
         be_ff  <= in_ctl.behind;
      end
   end

   assign out_valid      = v_ff;
   assign out_depth      = dep_ff;
   assign out_pix_x      = sx_ff;
   assign out_pix_y      = sy_ff;
   assign out_edge_flags = fl_ff;
   assign out_behind_eye = be_ff;

endmodule

[src/vpp_checker.sv]
// vpp_checker: port-level assertions for the projection unit, bound to the top level
// no dependencies
module vpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_pix_x,
   input logic [9:0]  rsp_pix_y,
   input logic [3:0]  rsp_edge_flags,
   input logic        rsp_behind_eye
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pix_x) && $stable(rsp_pix_y))
      else $error("stalled result changed");

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_behind_eye |-> rsp_pix_x == 10'd0 && rsp_pix_y == 10'd0
      && rsp_edge_flags == 4'd0)
      else $error("behind-eye result with screen data");

   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_pix_x) >= -10'sd39 && $signed(rsp_pix_x) <= 10'sd359
      && $signed(rsp_pix_y) >= -10'sd99 && $signed(rsp_pix_y) <= 10'sd299)
      else $error("screen position outside guard band");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_edge_flags[0] && rsp_edge_flags[1])
      && !(rsp_edge_flags[2] && rsp_edge_flags[3]))
      else $error("contradicting clip bits");

endmodule

bind vertex_perspective_project_clip_unit vpp_checker u_vpp_checker (.*);
